### rtl/core/ipa_pkg.sv
// Shared types, constants and helper functions for the IP address pool allocator.
package ipa_pkg;

    localparam int WORD_BITS     = 16;  // lease bits held in one memory word
    localparam int BIT_SEL_W     = 4;   // bit select inside a word
    localparam int FIRST_INDEX   = 10;  // lowest index that can be handed out
    localparam int LAST_TOP_BIT  = 4;   // highest usable bit in the last word of the pool
    localparam int MIN_HOST_BITS = 5;
    localparam int ADDR_W        = 32;
    localparam int TDATA_W       = 32;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int HOST_BITS_W   = 4;

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_PUT = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_POOL_ENABLED = 2'd0,
        CFG_NETWORK_BASE = 2'd1,
        CFG_HOST_BITS    = 2'd2
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HINT_RD,
        ST_HINT_CHK,
        ST_SCAN,
        ST_PUT_RD,
        ST_PUT_WR,
        ST_DONE
    } t_state;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic                 found;
        logic [BIT_SEL_W-1:0] pos;
    } t_hit;

    // Free entries of a word that lie inside the allocatable range.
    function automatic t_word free_bits(t_word data, logic first_word, logic last_word);
        t_word f;
        f = ~data;
        if (first_word) begin
            f[FIRST_INDEX-1:0] = '0;
        end
        if (last_word) begin
            f[WORD_BITS-1:LAST_TOP_BIT+1] = '0;
        end
        return f;
    endfunction

    // Lowest set bit.
    function automatic t_hit find_first(t_word f);
        t_hit h;
        h = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (f[i]) begin
                h.found = 1'b1;
                h.pos   = BIT_SEL_W'(i);
            end
        end
        return h;
    endfunction

    function automatic t_word bit_mask(logic [BIT_SEL_W-1:0] pos);
        return t_word'(1) << pos;
    endfunction

endpackage

### rtl/core/ipa_lease_ram.sv
// Lease bitmap storage: one write port, one registered read port.
module ipa_lease_ram #(
    parameter int ADDR_W = 6
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [ADDR_W-1:0]   i_waddr,
    input  ipa_pkg::t_word      i_wdata,
    input  logic                i_re,
    input  logic [ADDR_W-1:0]   i_raddr,
    output ipa_pkg::t_word      o_rdata
);

    ipa_pkg::t_word mem [2**ADDR_W];
    ipa_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/ip_address_pool_allocator_top.sv
// Top level of the IP address pool allocator: sequencer, registers and stream ports.
//
// Hands out and takes back host addresses of one subnet. The lease bitmap sits in a
// memory of 16-bit words and is swept by one word-wide find-first-free unit. After
// reset the block clears every word of the bitmap with s_axis_tready low;
// configuration writes are taken throughout. A request that hits the next-free hint
// passes through ST_HINT_RD and ST_HINT_CHK to ST_DONE, which hands over the result;
// otherwise the scan reads one word per cycle until it finds a free entry or reaches
// the last word of the pool, limited by the single memory read port. A release reads
// its word in ST_PUT_RD and clears its bit in ST_PUT_WR. One transaction is in flight
// at a time; a finished result waits in the output register while the next
// transaction is accepted. Write configuration only while the block is idle.
module ip_address_pool_allocator_top #(
    parameter int MAX_HOST_BITS = 10
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [ipa_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [ipa_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // request stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ipa_pkg::TDATA_W-1:0]         s_axis_tdata,  // return_address[31:0]
    input  logic                                s_axis_tuser,  // kind[0]
    // result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ipa_pkg::TDATA_W-1:0]         m_axis_tdata,  // granted_address[31:0]
    output logic                                m_axis_tuser   // granted[0]
);

    localparam int IDX_W   = MAX_HOST_BITS;
    localparam int WADDR_W = MAX_HOST_BITS - ipa_pkg::BIT_SEL_W;
    localparam int HB_W    = $clog2(MAX_HOST_BITS + 1);

    // configuration registers
    logic                            r_pool_en;
    logic [ipa_pkg::ADDR_W-1:0]      r_net_base;
    logic [ipa_pkg::HOST_BITS_W-1:0] r_host_bits;

    // sequencer state
    ipa_pkg::t_state              r_state, n_state;
    logic [WADDR_W-1:0]           r_clr, n_clr;
    logic [WADDR_W-1:0]           r_scan, n_scan;
    logic [IDX_W-1:0]             r_hint, n_hint;
    logic [IDX_W-1:0]             r_idx, n_idx;
    logic [ipa_pkg::ADDR_W-1:0]   r_res_addr, n_res_addr;
    logic                         r_res_granted, n_res_granted;
    logic [ipa_pkg::ADDR_W-1:0]   r_addr;
    logic                         r_out_valid;
    logic [ipa_pkg::TDATA_W-1:0]  r_out_data;
    logic                         r_out_granted;
    logic                         load_out;

    // memory port
    logic                         mem_we, mem_re;
    logic [WADDR_W-1:0]           mem_waddr, mem_raddr;
    ipa_pkg::t_word               mem_wdata, mem_rdata;

    // derived pool geometry
    logic [4:0]                   hb_wide;
    logic [HB_W-1:0]              hb_eff;
    logic [IDX_W:0]               size_full;
    logic [IDX_W-1:0]             pool_size;
    logic [WADDR_W:0]             lw_full;
    logic [WADDR_W-1:0]           last_word;

    logic [WADDR_W-1:0]           chk_word;
    ipa_pkg::t_word               free_vec;
    ipa_pkg::t_hit                hit;
    logic                         hint_ok;
    logic [IDX_W-1:0]             put_idx;
    logic [IDX_W-1:0]             scan_idx;
    logic                         s_accept;

    assign hb_wide = {1'b0, r_host_bits};

    always_comb begin
        if (hb_wide < 5'(ipa_pkg::MIN_HOST_BITS)) begin
            hb_eff = HB_W'(ipa_pkg::MIN_HOST_BITS);
        end else if (hb_wide > 5'(MAX_HOST_BITS)) begin
            hb_eff = HB_W'(MAX_HOST_BITS);
        end else begin
            hb_eff = HB_W'(hb_wide);
        end
    end

    assign size_full = (IDX_W+1)'(1) << hb_eff;
    assign pool_size = IDX_W'(size_full - (IDX_W+1)'(1));
    assign lw_full   = (WADDR_W+1)'(1) << (hb_eff - HB_W'(ipa_pkg::BIT_SEL_W));
    assign last_word = WADDR_W'(lw_full - (WADDR_W+1)'(1));

    assign chk_word = (r_state == ipa_pkg::ST_HINT_CHK) ? r_hint[IDX_W-1:ipa_pkg::BIT_SEL_W]
                                                        : r_scan;
    assign free_vec = ipa_pkg::free_bits(mem_rdata, chk_word == '0, chk_word == last_word);
    assign hit      = ipa_pkg::find_first(free_vec);
    assign hint_ok  = (r_hint[IDX_W-1:ipa_pkg::BIT_SEL_W] <= last_word)
                      && free_vec[r_hint[ipa_pkg::BIT_SEL_W-1:0]];
    assign put_idx  = r_addr[IDX_W-1:0] & pool_size;
    assign scan_idx = {r_scan, hit.pos};
    assign s_accept = s_axis_tvalid && s_axis_tready;

    ipa_lease_ram #(
        .ADDR_W (WADDR_W)
    ) u_lease_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_en   <= 1'b0;
            r_net_base  <= '0;
            r_host_bits <= ipa_pkg::HOST_BITS_W'(10);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                ipa_pkg::CFG_POOL_ENABLED: r_pool_en   <= i_cfg_wdata[0];
                ipa_pkg::CFG_NETWORK_BASE: r_net_base  <= i_cfg_wdata[ipa_pkg::ADDR_W-1:0];
                ipa_pkg::CFG_HOST_BITS:    r_host_bits <= i_cfg_wdata[ipa_pkg::HOST_BITS_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ipa_pkg::ST_CLEAR;
            r_clr         <= '0;
            r_hint        <= IDX_W'(ipa_pkg::FIRST_INDEX);
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_hint  <= n_hint;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_scan        <= n_scan;
        r_idx         <= n_idx;
        r_res_addr    <= n_res_addr;
        r_res_granted <= n_res_granted;
        if (s_accept) begin
            r_addr <= s_axis_tdata[ipa_pkg::ADDR_W-1:0];
        end
        if (load_out) begin
            r_out_data    <= r_res_addr;
            r_out_granted <= r_res_granted;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_clr         = r_clr;
        n_scan        = r_scan;
        n_hint        = r_hint;
        n_idx         = r_idx;
        n_res_addr    = r_res_addr;
        n_res_granted = r_res_granted;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = '0;
        s_axis_tready = 1'b0;
        load_out      = 1'b0;

        unique case (r_state)
            ipa_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + WADDR_W'(1);
                if (&r_clr) begin
                    n_state = ipa_pkg::ST_IDLE;
                end
            end
            ipa_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    n_res_addr    = '0;
                    n_res_granted = 1'b0;
                    if (!r_pool_en) begin
                        n_state = ipa_pkg::ST_DONE;
                    end else if (s_axis_tuser == ipa_pkg::KIND_GET) begin
                        n_state = ipa_pkg::ST_HINT_RD;
                    end else begin
                        n_state = ipa_pkg::ST_PUT_RD;
                    end
                end
            end
            ipa_pkg::ST_HINT_RD: begin
                mem_re    = 1'b1;
                mem_raddr = r_hint[IDX_W-1:ipa_pkg::BIT_SEL_W];
                n_state   = ipa_pkg::ST_HINT_CHK;
            end
            ipa_pkg::ST_HINT_CHK: begin
                if (hint_ok) begin
                    mem_we        = 1'b1;
                    mem_waddr     = r_hint[IDX_W-1:ipa_pkg::BIT_SEL_W];
                    mem_wdata     = mem_rdata
                                    | ipa_pkg::bit_mask(r_hint[ipa_pkg::BIT_SEL_W-1:0]);
                    n_hint        = r_hint + IDX_W'(1);
                    n_res_addr    = r_net_base + ipa_pkg::ADDR_W'(r_hint);
                    n_res_granted = 1'b1;
                    n_state       = ipa_pkg::ST_DONE;
                end else begin
                    // hint missed: sweep from the first word
                    mem_re    = 1'b1;
                    mem_raddr = '0;
                    n_scan    = '0;
                    n_state   = ipa_pkg::ST_SCAN;
                end
            end
            ipa_pkg::ST_SCAN: begin
                // read of the following word overlaps the check of this one
                mem_re    = 1'b1;
                mem_raddr = r_scan + WADDR_W'(1);
                if (hit.found) begin
                    mem_we        = 1'b1;
                    mem_waddr     = r_scan;
                    mem_wdata     = mem_rdata | ipa_pkg::bit_mask(hit.pos);
                    n_hint        = scan_idx + IDX_W'(1);
                    n_res_addr    = r_net_base + ipa_pkg::ADDR_W'(scan_idx);
                    n_res_granted = 1'b1;
                    n_state       = ipa_pkg::ST_DONE;
                end else if (r_scan == last_word) begin
                    n_state = ipa_pkg::ST_DONE;
                end else begin
                    n_scan = r_scan + WADDR_W'(1);
                end
            end
            ipa_pkg::ST_PUT_RD: begin
                // all-ones host part has no entry
                if (put_idx == pool_size) begin
                    n_state = ipa_pkg::ST_DONE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = put_idx[IDX_W-1:ipa_pkg::BIT_SEL_W];
                    n_idx     = put_idx;
                    n_state   = ipa_pkg::ST_PUT_WR;
                end
            end
            ipa_pkg::ST_PUT_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[IDX_W-1:ipa_pkg::BIT_SEL_W];
                mem_wdata = mem_rdata & ~ipa_pkg::bit_mask(r_idx[ipa_pkg::BIT_SEL_W-1:0]);
                n_hint    = r_idx;
                n_state   = ipa_pkg::ST_DONE;
            end
            ipa_pkg::ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = ipa_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ipa_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_granted;

    // checks
    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == ipa_pkg::ST_CLEAR || r_state == ipa_pkg::ST_HINT_CHK
                    || r_state == ipa_pkg::ST_SCAN || r_state == ipa_pkg::ST_PUT_WR))
        else $error("bitmap written outside a write state");

    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ipa_pkg::ST_CLEAR && (&r_clr)) |=> r_state == ipa_pkg::ST_IDLE)
        else $error("clearing pass did not end in idle");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ipa_pkg::ST_DONE))
        else $error("result loaded outside done state");

    a_zero_when_refused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tdata == '0)
        else $error("non-zero address without grant");

endmodule
